// ===== design/enhanced_clock_page_replacer_macros.svh =====
// Assertion macros shared by the replacer modules.
`ifndef ENHANCED_CLOCK_PAGE_REPLACER_MACROS_SVH
`define ENHANCED_CLOCK_PAGE_REPLACER_MACROS_SVH

// Implication checked on every rising edge, skipped while in reset.
`define ECPR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, skipped while in reset.
`define ECPR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ecpr_pkg.sv =====
// ----------------------------------------------------------------------------
// ecpr_pkg
// Types, constants and codes for the enhanced clock page replacer.
// ----------------------------------------------------------------------------
`default_nettype none
package ecpr_pkg;
  localparam int NUM_FRAMES  = 64;
  localparam int OWNER_BITS  = 8;
  localparam int FRAME_BITS  = $clog2(NUM_FRAMES);
  localparam int SCAN_BITS   = $clog2(NUM_FRAMES + 1);

  localparam logic [1:0] KIND_INSERT  = 2'd0;
  localparam logic [1:0] KIND_ACCESS  = 2'd1;
  localparam logic [1:0] KIND_REPLACE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_ERR   = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] frame_no;
    logic [7:0] proc_id;
    logic       is_write;
    logic       init_ref;
    logic       init_dirty;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] victim_frame;
    logic [7:0] victim_owner;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic do_insert;  // write links and bits for an insert
    logic do_access;  // set referenced/dirty
    logic scan_start; // cursor to hand, clear step count
    logic scan_step;  // examine cursor entry and advance
    logic evict_rd;   // read victim links
    logic evict_wr;   // unlink victim, update hand
    logic [1:0] pass; // current scan pass
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic insert_ok;
    logic access_ok;
    logic nonempty;
    logic hit;        // cursor entry matches the current pass
    logic wrapped;    // pass went round the ring
  } sts_t;
endpackage
`default_nettype wire

// ===== design/ecpr_datapath.sv =====
// ----------------------------------------------------------------------------
// ecpr_datapath
// Frame ring storage, hand, scan cursor and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module ecpr_datapath (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_take,
  input  ecpr_pkg::req_t   req_in,
  input  ecpr_pkg::cmd_t   cmd,
  output ecpr_pkg::sts_t   sts,
  output ecpr_pkg::rsp_t   rsp_ok
);
  import ecpr_pkg::*;

  logic [FRAME_BITS-1:0] next_mem  [NUM_FRAMES];
  logic [FRAME_BITS-1:0] prev_mem  [NUM_FRAMES];
  logic [OWNER_BITS-1:0] owner_mem [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] ref_bits, dirty_bits, resident;
  logic [FRAME_BITS-1:0] hand, cursor, victim;
  logic                  ring_nonempty;
  logic [SCAN_BITS-1:0]  steps;
  req_t                  req;

  // Insert phase: the first phase reads prev of hand and links the new frame
  // forward, the second closes the ring behind it.
  logic                  ins_phase;
  logic [FRAME_BITS-1:0] rd_next, rd_prev;
  logic [OWNER_BITS-1:0] rd_owner;

  logic [FRAME_BITS-1:0] fr;
  assign fr = req.frame_no[FRAME_BITS-1:0];

  assign sts.insert_ok = !resident[fr];
  assign sts.access_ok = resident[fr];
  assign sts.nonempty  = ring_nonempty;
  assign sts.hit       = !ref_bits[cursor] && (dirty_bits[cursor] == cmd.pass[0]);
  assign sts.wrapped   = (steps != '0) && (cursor == hand);

  assign rsp_ok.status       = ST_OK;
  assign rsp_ok.victim_frame = 6'(victim);
  assign rsp_ok.victim_owner = 8'(rd_owner);

  always_ff @(posedge clk) begin
    if (in_take) req <= req_in;
    if (cmd.do_insert && !ins_phase) rd_prev <= prev_mem[hand];
    else if (cmd.evict_rd) rd_prev <= prev_mem[cursor];
    if (cmd.evict_rd) begin
      rd_next  <= next_mem[cursor];
      rd_owner <= owner_mem[cursor];
      victim   <= cursor;
    end
    if (cmd.scan_start) cursor <= hand;
    else if (cmd.scan_step) cursor <= next_mem[cursor];
    // one write per link table per cycle
    if (cmd.do_insert && !ins_phase) next_mem[fr] <= ring_nonempty ? hand : fr;
    else if (cmd.do_insert && ins_phase && ring_nonempty) next_mem[rd_prev] <= fr;
    else if (cmd.evict_wr) next_mem[rd_prev] <= rd_next;
    if (cmd.do_insert && !ins_phase && ring_nonempty) prev_mem[hand] <= fr;
    else if (cmd.do_insert && ins_phase) prev_mem[fr] <= ring_nonempty ? rd_prev : fr;
    else if (cmd.evict_wr) prev_mem[rd_next] <= rd_prev;
    if (cmd.do_insert && ins_phase) owner_mem[fr] <= OWNER_BITS'(req.proc_id);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_bits      <= '0;
      dirty_bits    <= '0;
      resident      <= '0;
      hand          <= '0;
      ring_nonempty <= 1'b0;
      steps         <= '0;
      ins_phase     <= 1'b0;
    end else begin
      if (cmd.do_insert) ins_phase <= !ins_phase;
      if (cmd.do_insert && ins_phase) begin
        ref_bits[fr]   <= req.init_ref;
        dirty_bits[fr] <= req.init_dirty;
        resident[fr]   <= 1'b1;
        if (!ring_nonempty) begin
          hand          <= fr;
          ring_nonempty <= 1'b1;
        end
      end
      if (cmd.do_access) begin
        ref_bits[fr] <= 1'b1;
        if (req.is_write) dirty_bits[fr] <= 1'b1;
      end
      if (cmd.scan_start) steps <= '0;
      else if (cmd.scan_step) begin
        steps <= steps + 1'b1;
        // second pass clears referenced bits it passes over
        if (cmd.pass == 2'd1) ref_bits[cursor] <= 1'b0;
      end
      if (cmd.evict_wr) begin
        resident[victim]   <= 1'b0;
        ref_bits[victim]   <= 1'b0;
        dirty_bits[victim] <= 1'b0;
        if (rd_next == victim) begin
          ring_nonempty <= 1'b0;
          hand          <= '0;
        end else begin
          hand <= rd_next;
        end
      end
    end
  end

  `include "enhanced_clock_page_replacer_macros.svh"
  `ECPR_ASSERT_IMP(a_ring_has_resident, ring_nonempty, resident != '0, "ring flag without frames")
  `ECPR_ASSERT_IMP(a_hand_resident, ring_nonempty, resident[hand], "hand on non-resident frame")
  `ECPR_ASSERT_NXT(a_evict_clears, cmd.evict_wr, !resident[$past(victim)], "victim still resident")
endmodule
`default_nettype wire

// ===== design/ecpr_ctrl.sv =====
// ----------------------------------------------------------------------------
// ecpr_ctrl
// Sequencer for insert, access and the four-pass replacement scan.
// ----------------------------------------------------------------------------
`default_nettype none
module ecpr_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_stall,
  input  ecpr_pkg::req_t   req_in,
  output logic             out_valid,
  input  wire              out_stall,
  output ecpr_pkg::rsp_t   rsp,
  output logic             in_take,
  output ecpr_pkg::cmd_t   cmd,
  input  ecpr_pkg::sts_t   sts,
  input  ecpr_pkg::rsp_t   rsp_ok
);
  import ecpr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0, S_DECODE = 3'd1, S_INSERT = 3'd2,
                         S_SCAN = 3'd3, S_EVRD = 3'd4, S_EVWR = 3'd5, S_OUT = 3'd6;

  logic [2:0] state, state_next;
  logic [1:0] pass, pass_next;
  logic [1:0] kind;
  logic       busy;
  rsp_t       rsp_dec;

  assign in_take  = in_valid && !in_stall;
  assign in_stall = busy;

  // result for every request that does not evict
  always_comb begin
    rsp_dec = '0;
    if (kind == KIND_INSERT && !sts.insert_ok) rsp_dec.status = ST_ERR;
    else if (kind == KIND_ACCESS && !sts.access_ok) rsp_dec.status = ST_ERR;
    else if (kind == KIND_REPLACE && !sts.nonempty) rsp_dec.status = ST_EMPTY;
  end

  always_comb begin
    cmd        = '0;
    cmd.pass   = pass;
    state_next = state;
    pass_next  = pass;
    case (state)
      S_IDLE:   if (in_take) state_next = S_DECODE;
      S_DECODE: begin
        if (kind == KIND_INSERT && sts.insert_ok) begin
          cmd.do_insert = 1'b1;
          state_next    = S_INSERT;
        end else if (kind == KIND_REPLACE && sts.nonempty) begin
          cmd.scan_start = 1'b1;
          pass_next      = 2'd0;
          state_next     = S_SCAN;
        end else begin
          if (kind == KIND_ACCESS && sts.access_ok) cmd.do_access = 1'b1;
          state_next = S_OUT;
        end
      end
      S_INSERT: begin
        cmd.do_insert = 1'b1;
        state_next    = S_OUT;
      end
      S_SCAN: begin
        if (sts.wrapped) begin
          cmd.scan_start = 1'b1;
          pass_next      = pass + 2'd1;
        end else if (sts.hit) begin
          cmd.evict_rd = 1'b1;
          state_next   = S_EVRD;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_EVRD: state_next = S_EVWR;
      S_EVWR: begin
        cmd.evict_wr = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT:  if (out_valid && !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pass      <= '0;
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pass  <= pass_next;
      if (in_take) begin
        busy <= 1'b1;
        kind <= req_in.kind;
      end else if (out_valid && !out_stall) begin
        busy <= 1'b0;
      end
      if (out_valid) begin
        if (!out_stall) out_valid <= 1'b0;
      end else if (state == S_OUT) begin
        out_valid <= 1'b1;
      end
      // build the result ahead of presenting it
      if (state == S_EVWR) rsp <= rsp_ok;
      else if (state == S_DECODE) rsp <= rsp_dec;
    end
  end

  `include "enhanced_clock_page_replacer_macros.svh"
  `ECPR_ASSERT_IMP(a_out_only_done, out_valid, state == S_OUT, "result outside output state")
  `ECPR_ASSERT_IMP(a_stall_busy, state != S_IDLE, in_stall, "request taken while busy")
  `ECPR_ASSERT_IMP(a_pass_bound, state == S_SCAN, pass != 2'd3 || !sts.wrapped, "scan ran past four passes")
endmodule
`default_nettype wire

// ===== design/enhanced_clock_page_replacer.sv =====
// ----------------------------------------------------------------------------
// enhanced_clock_page_replacer
// Enhanced second-chance clock replacement over a ring of resident frames.
// ----------------------------------------------------------------------------
// Usage:
//   in  channel (in_valid/in_stall/in_data): one request, kind insert,
//       access or replace. The block takes one request at a time and stalls
//       the input until its result has been taken.
//   out channel (out_valid/out_stall/out_data): exactly one result per
//   request: status, victim frame and owner.
//   Sequence: an insert is decoded, linked in a forward and a closing phase
//   and output; an access or any error is decoded and output; a replace is
//   decoded, scans ring entries with a restart at each new pass, up to four
//   passes, then reads and unlinks the victim. The scan visits one entry a
//   cycle between restarts through the single link-memory read path.
//   The next request can be taken in the cycle after the result is taken.
//   Reset: rst clears resident, referenced and dirty bits, the hand and
//   the control state; links and owners are written on insert.
//   A stalled result holds steady until taken.
// ----------------------------------------------------------------------------
`default_nettype none
module enhanced_clock_page_replacer (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_stall,
  input  ecpr_pkg::req_t   in_data,
  output logic             out_valid,
  input  wire              out_stall,
  output ecpr_pkg::rsp_t   out_data
);
  import ecpr_pkg::*;

  cmd_t cmd;
  sts_t sts;
  rsp_t rsp_ok;
  logic in_take;

  ecpr_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .req_in(in_data), .out_valid, .out_stall,
    .rsp(out_data), .in_take, .cmd, .sts, .rsp_ok
  );

  ecpr_datapath u_dp (
    .clk, .rst, .in_take, .req_in(in_data), .cmd, .sts, .rsp_ok
  );
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives insert, access, replace and undefined-kind requests into the replacer,
// predicts each result with a behavioural ring model and checks them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import ecpr_pkg::*;

  class victim_scoreboard;
    logic [5:0] nxt [64];
    logic [5:0] prv [64];
    logic [7:0] owner [64];
    bit         refd [64];
    bit         dirty [64];
    bit         resident [64];
    logic [5:0] hand;
    bit         nonempty;
    rsp_t       pending [$];
    int         errors;

    function new();
      for (int i = 0; i < 64; i++) begin
        nxt[i] = 0; prv[i] = 0; owner[i] = 0;
        refd[i] = 0; dirty[i] = 0; resident[i] = 0;
      end
      hand = 0;
      nonempty = 0;
      errors = 0;
    endfunction

    function int find_victim(bit want_dirty, bit clear_ref);
      logic [5:0] cur;
      cur = hand;
      for (int i = 0; i < 64; i++) begin
        if (!refd[cur] && dirty[cur] == want_dirty) return int'(cur);
        if (clear_ref) refd[cur] = 0;
        cur = nxt[cur];
        if (cur == hand) break;
      end
      return -1;
    endfunction

    function void note_request(req_t r);
      rsp_t o;
      int v;
      logic [5:0] f, b, nx, pv;
      o = '0;
      o.status = ST_OK;
      f = r.frame_no;
      if (r.kind == KIND_INSERT) begin
        if (resident[f]) o.status = ST_ERR;
        else begin
          owner[f] = r.proc_id;
          refd[f] = r.init_ref;
          dirty[f] = r.init_dirty;
          resident[f] = 1;
          if (!nonempty) begin
            nxt[f] = f; prv[f] = f; hand = f; nonempty = 1;
          end else begin
            b = prv[hand];
            prv[f] = b; nxt[f] = hand; nxt[b] = f; prv[hand] = f;
          end
        end
      end else if (r.kind == KIND_ACCESS) begin
        if (!resident[f]) o.status = ST_ERR;
        else begin
          refd[f] = 1;
          if (r.is_write) dirty[f] = 1;
        end
      end else if (r.kind == KIND_REPLACE) begin
        if (!nonempty) o.status = ST_EMPTY;
        else begin
          v = find_victim(0, 0);
          if (v < 0) v = find_victim(1, 1);
          if (v < 0) v = find_victim(0, 0);
          if (v < 0) v = find_victim(1, 0);
          if (v < 0) o.status = ST_ERR;
          else begin
            f = v[5:0];
            nx = nxt[f]; pv = prv[f];
            o.victim_frame = f;
            o.victim_owner = owner[f];
            if (nx == f) begin
              nonempty = 0; hand = 0;
            end else begin
              nxt[pv] = nx; prv[nx] = pv; hand = nx;
            end
            resident[f] = 0; refd[f] = 0; dirty[f] = 0;
          end
        end
      end
      pending.push_back(o);
    endfunction

    function void check_result(rsp_t got);
      rsp_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.status !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $realtime, exp_r.status,
                 got.status);
        errors++;
      end
      if (got.victim_frame !== exp_r.victim_frame) begin
        $display("%0t: victim_frame expected %0d actual %0d", $realtime,
                 exp_r.victim_frame, got.victim_frame);
        errors++;
      end
      if (got.victim_owner !== exp_r.victim_owner) begin
        $display("%0t: victim_owner expected %0d actual %0d", $realtime,
                 exp_r.victim_owner, got.victim_owner);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  rsp_t out_data;
  bit   calm;

  victim_scoreboard sb;

  enhanced_clock_page_replacer i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // receiver side: random stall bursts, check every accepted result
  initial begin
    int n;
    n = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) sb.check_result(out_data);
      if (n > 0) n--;
      else if (!calm && $urandom_range(0, 5) == 0) n = $urandom_range(1, 6);
      out_stall <= (n > 0);
    end
  end

  task automatic send_request(req_t r);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(r);
  endtask

  function automatic req_t make_req(logic [1:0] k, logic [5:0] f);
    req_t r;
    r = req_t'($urandom);
    r.kind = k;
    r.frame_no = f;
    return r;
  endfunction

  function automatic logic [5:0] pick_frame(bit want_resident);
    logic [5:0] f;
    for (int t = 0; t < 64; t++) begin
      f = 6'($urandom_range(0, 63));
      if (sb.resident[f] == want_resident) return f;
    end
    return 6'($urandom_range(0, 63));
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    req_t r;
    int k;
    sb = new();
    calm = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty replace, extremes, error cases, single-frame ring
    send_request(make_req(KIND_REPLACE, 6'd0));
    r = '0; r.kind = KIND_INSERT; r.frame_no = 6'd63; r.proc_id = 8'hff;
    r.init_ref = 1; r.init_dirty = 1; r.is_write = 1;
    send_request(r);
    send_request(r);
    send_request(make_req(KIND_ACCESS, 6'd0));
    send_request(make_req(KIND_REPLACE, 6'd5));
    send_request(make_req(KIND_REPLACE, 6'd5));
    r = '0; r.kind = KIND_INSERT;
    send_request(r);
    r.frame_no = 6'd1; r.init_dirty = 1; r.proc_id = 8'h5a;
    send_request(r);
    r.frame_no = 6'd2; r.init_ref = 1; r.init_dirty = 0; r.proc_id = 8'ha5;
    send_request(r);
    r = '0; r.kind = KIND_ACCESS; r.frame_no = 6'd0; r.is_write = 1;
    send_request(r);
    r.frame_no = 6'd1; r.is_write = 0;
    send_request(r);
    send_request(make_req(2'd3, 6'd7));
    repeat (4) send_request(make_req(KIND_REPLACE, 6'd0));

    // hold off until everything is out
    drain();

    for (int i = 0; i < 600; i++) begin
      if (i == 300) drain();
      if (i == 520) calm = 1;
      k = $urandom_range(0, 99);
      if (k < 40) begin
        r = make_req(KIND_INSERT, pick_frame(k >= 4 ? 1'b0 : 1'b1));
      end else if (k < 75) begin
        r = make_req(KIND_ACCESS, pick_frame(k >= 43 ? 1'b1 : 1'b0));
      end else if (k < 97) begin
        r = make_req(KIND_REPLACE, 6'($urandom_range(0, 63)));
      end else begin
        r = make_req(2'd3, 6'($urandom_range(0, 63)));
      end
      send_request(r);
    end
    drain();
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end
endmodule
